/* design/cpm_pkg.sv */
// shared types, constants and codes for the controller-to-pointer mapper
// used by every module of the block; depends on nothing else
package cpm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LEVEL_W = 15;
	localparam int GAIN_W = 7;
	localparam int MODE_W = 2;
	localparam int KIND_W = 3;
	localparam int VALUE_W = 8;
	localparam int NUM_KEYS = 4;
	localparam int NUM_CAND = 4;
	localparam int MAX_EVENTS = 5;
	localparam int CNT_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int STEP_MAX = 127;

	// item kinds
	localparam logic [MODE_W-1:0] MODE_STICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd2;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_MOVE_X = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOVE_Y = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LEFT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SYNC = 3'd6;

	// configuration register indexes
	localparam logic [1:0] REG_DEADZONE = 2'd0;
	localparam logic [1:0] REG_GAIN = 2'd1;
	localparam logic [1:0] REG_PRESS = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	localparam logic [LEVEL_W-1:0] DEADZONE_RST = 15'd6554;
	localparam logic [GAIN_W-1:0] GAIN_RST = 7'd18;
	localparam logic [LEVEL_W-1:0] PRESS_RST = 15'd21299;
	localparam logic [LEVEL_W-1:0] RELEASE_RST = 15'd14746;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic signed [VALUE_W-1:0] value;
	} event_t;

	typedef struct packed {
		event_t [MAX_EVENTS-1:0] ev;
		logic [CNT_W-1:0] cnt;
	} bundle_t;

	// bit0 left, bit1 right, bit2 middle, bit3 escape
	typedef struct packed {
		logic [NUM_KEYS-1:0] want;
		logic [NUM_KEYS-1:0] diff;
	} key_lanes_t;

endpackage

/* design/cpm_axis_lane.sv */
// one stick axis lane: deadzone test, gain multiply, rounding and sign
// depends on cpm_pkg
module cpm_axis_lane import cpm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter bit FLIP = 1'b0
) (
	input  logic                          clk,
	input  logic                          load_s1,
	input  logic                          load_s2,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [LEVEL_W-1:0]            deadzone_level,
	input  logic [GAIN_W-1:0]             move_gain,
	output logic signed [VALUE_W-1:0]     step
);

	localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
	localparam int PROD_W = SAMPLE_BITS + GAIN_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int Q_W = SUM_W - (SAMPLE_BITS - 1);
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SAMPLE_BITS - 2);

	logic                   neg;
	logic [SAMPLE_BITS-1:0] mag;
	logic                   active;
	logic                   neg_s1;
	logic                   act_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic                   neg_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic [SUM_W-1:0]       sum;
	logic [Q_W-1:0]         q;
	logic [VALUE_W-2:0]     sat;

	always_comb begin
		neg = sample[SAMPLE_BITS-1];
		mag = neg ? $unsigned(-sample) : $unsigned(sample);
		active = CMP_W'(mag) > CMP_W'(deadzone_level);
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mag_s1 <= mag;
			neg_s1 <= neg ^ FLIP;
			act_s1 <= active;
		end
		if (load_s2) begin
			prod_s2 <= act_s1 ? PROD_W'(mag_s1) * PROD_W'(move_gain) : '0;
			neg_s2 <= neg_s1;
		end
	end

	// round half away from zero on the magnitude, then apply the sign
	always_comb begin
		sum = SUM_W'(prod_s2) + HALF;
		q = sum[SUM_W-1:SAMPLE_BITS-1];
		sat = (q > Q_W'(STEP_MAX)) ? (VALUE_W-1)'(STEP_MAX) : q[VALUE_W-2:0];
		step = neg_s2 ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
	end

endmodule

/* design/cpm_key_unit.sv */
// key lanes: trigger hysteresis, button latch and key change detection
// depends on cpm_pkg
module cpm_key_unit import cpm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [MODE_W-1:0]             mode,
	input  logic signed [SAMPLE_BITS-1:0] first_value,
	input  logic signed [SAMPLE_BITS-1:0] second_value,
	input  logic [NUM_KEYS-1:0]           buttons,
	input  logic [LEVEL_W-1:0]            press_level,
	input  logic [LEVEL_W-1:0]            release_level,
	input  logic                          load_s2,
	output key_lanes_t                    keys_s2
);

	localparam int LW = (SAMPLE_BITS - 1 > LEVEL_W) ? SAMPLE_BITS - 1 : LEVEL_W;

	logic                trigger_held_q;
	logic                grip_held_q;
	logic [NUM_KEYS-1:0] button_latch_q;
	logic [NUM_KEYS-1:0] key_state_q;
	logic                trig_nxt;
	logic                grip_nxt;
	logic                trig_use;
	logic                grip_use;
	logic [NUM_KEYS-1:0] latch_use;
	logic [LW-1:0]       trig_mag;
	logic [LW-1:0]       grip_mag;
	logic                key_item;
	key_lanes_t          keys;
	key_lanes_t          keys_s1;

	always_comb begin
		trig_mag = LW'(first_value[SAMPLE_BITS-2:0]);
		grip_mag = LW'(second_value[SAMPLE_BITS-2:0]);
		// negative samples are never held
		trig_nxt = !first_value[SAMPLE_BITS-1] &&
			(trigger_held_q ? trig_mag >= LW'(release_level) : trig_mag >= LW'(press_level));
		grip_nxt = !second_value[SAMPLE_BITS-1] &&
			(grip_held_q ? grip_mag >= LW'(release_level) : grip_mag >= LW'(press_level));
		trig_use = (mode == MODE_TRIGGER) ? trig_nxt : trigger_held_q;
		grip_use = (mode == MODE_TRIGGER) ? grip_nxt : grip_held_q;
		latch_use = (mode == MODE_BUTTON) ? buttons : button_latch_q;
		key_item = (mode inside {MODE_TRIGGER, MODE_BUTTON});
		// latch: bit0 a, bit1 b, bit2 system, bit3 click
		keys.want = {latch_use[2], latch_use[3], grip_use | latch_use[1],
			trig_use | latch_use[0]};
		keys.diff = keys.want ^ key_state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_held_q <= 1'b0;
			grip_held_q <= 1'b0;
			button_latch_q <= '0;
			key_state_q <= '0;
		end else if (in_fire && key_item) begin
			trigger_held_q <= trig_use;
			grip_held_q <= grip_use;
			button_latch_q <= latch_use;
			key_state_q <= keys.want;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			keys_s1 <= keys;
		end
		if (load_s2) begin
			keys_s2 <= keys_s1;
		end
	end

`ifndef NO_ASSERTIONS
	a_stick_keeps_keys: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && mode == MODE_STICK |=> key_state_q == $past(key_state_q))
		else $error("key state changed on a stick item");
`endif

endmodule

/* design/cpm_merge.sv */
// merge stage: packs lane results into an event bundle, queues bundles
// and sends events one per transfer; depends on cpm_pkg
module cpm_merge import cpm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s2,
	input  logic [MODE_W-1:0]         mode_s2,
	input  logic signed [VALUE_W-1:0] step_x,
	input  logic signed [VALUE_W-1:0] step_y,
	input  key_lanes_t                keys_s2,
	output logic                      take_s2,
	output logic                      out_valid,
	input  logic                      out_ready,
	output event_t                    out_event,
	output logic                      out_last
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	event_t [NUM_CAND-1:0] cand;
	logic [NUM_CAND-1:0]   cand_en;
	bundle_t               bundle;
	logic [CNT_W-1:0]      n;
	bundle_t               queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [LVL_W-1:0]      level_q;
	logic [CNT_W-1:0]      idx_q;
	bundle_t               head;
	logic                  full;
	logic                  push;
	logic                  pop;
	logic                  out_fire;

	always_comb begin
		for (int i = 0; i < NUM_CAND; i++) begin
			cand[i].kind = KIND_LEFT + KIND_W'(i);
			cand[i].value = VALUE_W'(keys_s2.want[i]);
		end
		cand_en = '0;
		case (mode_s2)
			MODE_STICK: begin
				cand[0].kind = KIND_MOVE_X;
				cand[0].value = step_x;
				cand[1].kind = KIND_MOVE_Y;
				cand[1].value = step_y;
				cand_en[0] = step_x != '0;
				cand_en[1] = step_y != '0;
			end
			MODE_TRIGGER, MODE_BUTTON: begin
				cand_en = keys_s2.diff;
			end
			default: begin
				cand_en = '0;
			end
		endcase

		// compact the enabled lanes in order, then close with a sync
		bundle = '0;
		n = '0;
		for (int i = 0; i < NUM_CAND; i++) begin
			if (cand_en[i]) begin
				bundle.ev[n] = cand[i];
				n = n + 1'b1;
			end
		end
		if (n != '0) begin
			bundle.ev[n].kind = KIND_SYNC;
			bundle.ev[n].value = '0;
			bundle.cnt = n + 1'b1;
		end
	end

	assign full = level_q == LVL_W'(QUEUE_DEPTH);
	assign take_s2 = (bundle.cnt == '0) || !full;
	assign push = valid_s2 && bundle.cnt != '0 && !full;

	assign head = queue_q[rd_ptr_q];
	assign out_valid = level_q != '0;
	assign out_event = head.ev[idx_q];
	assign out_last = idx_q == head.cnt - 1'b1;
	assign out_fire = out_valid && out_ready;
	assign pop = out_fire && out_last;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
			idx_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				idx_q <= '0;
			end else if (out_fire) begin
				idx_q <= idx_q + 1'b1;
			end
			case ({push, pop})
				2'b10: level_q <= level_q + 1'b1;
				2'b01: level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(QUEUE_DEPTH))
		else $error("bundle queue overflow");
	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q < head.cnt)
		else $error("event index past end of bundle");
	a_bundle_has_sync: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> bundle.cnt >= CNT_W'(2) && bundle.ev[bundle.cnt - 1'b1].kind == KIND_SYNC)
		else $error("queued bundle does not end in a sync");
`endif

endmodule

/* design/controller_to_pointer_mapper.sv */
// Hand-controller to pointer mapper. Stick, trigger and button samples enter
// on the slave stream; pointer moves, key changes and syncs leave on the master
// stream, one event per transfer. An item is taken every cycle, unless a full
// queue holds the pipeline back, into a three-stage pipeline (two axis lanes
// with their own multiplier and four key lanes, then a merge stage), and its
// events are queued as one bundle; a queue of two bundles parts the input from
// the output. An item causes as many output transfers as events: none, two or
// three for a stick sample, up to five for a trigger or button sample, so the
// master channel sets the sustained rate. The first event of an item is offered
// once it has passed the stage-one and stage-two registers and its bundle is
// written into the queue. Configuration writes are meant for an idle block.
// depends on cpm_pkg, cpm_axis_lane, cpm_key_unit, cpm_merge
module controller_to_pointer_mapper import cpm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_W = ((2 * SAMPLE_BITS + NUM_KEYS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// first_value, second_value, button_a, button_b, button_system, button_click
	input  logic [IN_W-1:0]      s_tdata,
	// mode
	input  logic [MODE_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// event_value
	output logic [VALUE_W-1:0]   m_tdata,
	// event_kind
	output logic [KIND_W-1:0]    m_tuser,
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data
);

	logic [LEVEL_W-1:0]          deadzone_level_q;
	logic [GAIN_W-1:0]           move_gain_q;
	logic [LEVEL_W-1:0]          press_level_q;
	logic [LEVEL_W-1:0]          release_level_q;
	logic                        s_fire;
	logic                        valid_s1;
	logic                        valid_s2;
	logic [MODE_W-1:0]           mode_s1;
	logic [MODE_W-1:0]           mode_s2;
	logic                        take_s2;
	logic                        s2_free;
	logic                        load_s2;
	logic signed [SAMPLE_BITS-1:0] first_value;
	logic signed [SAMPLE_BITS-1:0] second_value;
	logic [NUM_KEYS-1:0]         buttons;
	logic signed [VALUE_W-1:0]   step_x;
	logic signed [VALUE_W-1:0]   step_y;
	key_lanes_t                  keys_s2;
	event_t                      out_event;

	assign first_value = s_tdata[SAMPLE_BITS-1:0];
	assign second_value = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	// a, b, system, click from the lowest bit up
	assign buttons = s_tdata[2*SAMPLE_BITS+NUM_KEYS-1:2*SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_level_q <= DEADZONE_RST;
			move_gain_q <= GAIN_RST;
			press_level_q <= PRESS_RST;
			release_level_q <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEADZONE: deadzone_level_q <= cfg_data;
				REG_GAIN: move_gain_q <= cfg_data[GAIN_W-1:0];
				REG_PRESS: press_level_q <= cfg_data;
				REG_RELEASE: release_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance: stage two moves on when the merge stage takes it
	assign s2_free = !valid_s2 || take_s2;
	assign s_tready = !valid_s1 || s2_free;
	assign s_fire = s_tvalid && s_tready;
	assign load_s2 = valid_s1 && s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_fire;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_s1 <= s_tuser;
		end
		if (load_s2) begin
			mode_s2 <= mode_s1;
		end
	end

	cpm_axis_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FLIP        (1'b0)
	) u_lane_x (
		.clk            (clk),
		.load_s1        (s_fire),
		.load_s2        (load_s2),
		.sample         (first_value),
		.deadzone_level (deadzone_level_q),
		.move_gain      (move_gain_q),
		.step           (step_x)
	);

	// y axis grows downward on screen
	cpm_axis_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FLIP        (1'b1)
	) u_lane_y (
		.clk            (clk),
		.load_s1        (s_fire),
		.load_s2        (load_s2),
		.sample         (second_value),
		.deadzone_level (deadzone_level_q),
		.move_gain      (move_gain_q),
		.step           (step_y)
	);

	cpm_key_unit #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_keys (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (s_fire),
		.mode          (s_tuser),
		.first_value   (first_value),
		.second_value  (second_value),
		.buttons       (buttons),
		.press_level   (press_level_q),
		.release_level (release_level_q),
		.load_s2       (load_s2),
		.keys_s2       (keys_s2)
	);

	cpm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.mode_s2   (mode_s2),
		.step_x    (step_x),
		.step_y    (step_y),
		.keys_s2   (keys_s2),
		.take_s2   (take_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_event (out_event),
		.out_last  (m_tlast)
	);

	assign m_tdata = out_event.value;
	assign m_tuser = out_event.kind;

endmodule

/* tb/sv/testbench.sv */
// testbench for controller_to_pointer_mapper: stick, trigger and button samples under
// several register settings and idle patterns, every event checked against a predictor
// depends on cpm_pkg and the design sources of the block
module testbench import cpm_pkg::*; ();

	localparam int SAMPLE_W = SAMPLE_BITS_DEF;
	localparam int DATA_W = ((2 * SAMPLE_W + NUM_KEYS + 7) / 8) * 8;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int DRAIN_PAD = 10;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [VALUE_W-1:0] value;
		logic last;
	} pointer_event_t;

	class pointer_event_board;
		int deadzone;
		int gain;
		int press_lvl;
		int release_lvl;
		bit trigger_held;
		bit grip_held;
		logic [NUM_KEYS-1:0] button_latch;
		logic [NUM_KEYS-1:0] key_state;
		pointer_event_t pending_events[$];
		int errors;
		int checked;

		function new();
			deadzone = int'(DEADZONE_RST);
			gain = int'(GAIN_RST);
			press_lvl = int'(PRESS_RST);
			release_lvl = int'(RELEASE_RST);
			trigger_held = 0;
			grip_held = 0;
			button_latch = '0;
			key_state = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [LEVEL_W-1:0] val);
			case (idx)
				REG_DEADZONE: deadzone = int'(val);
				REG_GAIN: gain = int'(val[GAIN_W-1:0]);
				REG_PRESS: press_lvl = int'(val);
				REG_RELEASE: release_lvl = int'(val);
				default: ;
			endcase
		endfunction

		function int pending_count();
			return pending_events.size();
		endfunction

		// pointer step for one axis, rounded half away from zero
		function int axis_step(logic signed [SAMPLE_W-1:0] v);
			int mag;
			int q;
			mag = (v < 0) ? -int'(v) : int'(v);
			if (mag <= deadzone)
				return 0;
			q = (mag * gain + (1 << (SAMPLE_W - 2))) >> (SAMPLE_W - 1);
			if (q > STEP_MAX)
				q = STEP_MAX;
			return (v < 0) ? -q : q;
		endfunction

		function bit hysteresis(logic signed [SAMPLE_W-1:0] v, bit held);
			return held ? (int'(v) >= release_lvl) : (int'(v) >= press_lvl);
		endfunction

		function void note_item(logic [MODE_W-1:0] mode, logic signed [SAMPLE_W-1:0] fv,
				logic signed [SAMPLE_W-1:0] sv, logic [NUM_KEYS-1:0] buttons);
			pointer_event_t evs[$];
			pointer_event_t ev;
			int sx;
			int sy;
			logic [NUM_KEYS-1:0] want;
			logic [NUM_KEYS-1:0] diff;
			ev.last = 1'b0;
			if (mode == MODE_STICK) begin
				sx = axis_step(fv);
				sy = -axis_step(sv);
				if (sx != 0) begin
					ev.kind = KIND_MOVE_X;
					ev.value = VALUE_W'(sx);
					evs.push_back(ev);
				end
				if (sy != 0) begin
					ev.kind = KIND_MOVE_Y;
					ev.value = VALUE_W'(sy);
					evs.push_back(ev);
				end
			end else if (mode == MODE_TRIGGER || mode == MODE_BUTTON) begin
				if (mode == MODE_TRIGGER) begin
					trigger_held = hysteresis(fv, trigger_held);
					grip_held = hysteresis(sv, grip_held);
				end else begin
					button_latch = buttons;
				end
				// latch: a, b, system, click; keys: left, right, middle, escape
				want = {button_latch[2], button_latch[3], grip_held | button_latch[1],
					trigger_held | button_latch[0]};
				diff = want ^ key_state;
				for (int i = 0; i < NUM_KEYS; i++) begin
					if (diff[i]) begin
						ev.kind = KIND_LEFT + KIND_W'(i);
						ev.value = want[i] ? VALUE_W'(1) : VALUE_W'(0);
						evs.push_back(ev);
					end
				end
				key_state = want;
			end
			if (evs.size() == 0)
				return;
			ev.kind = KIND_SYNC;
			ev.value = '0;
			ev.last = 1'b1;
			evs.push_back(ev);
			foreach (evs[i])
				pending_events.push_back(evs[i]);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_event(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value, logic last);
			pointer_event_t exp_ev;
			if (pending_events.size() == 0) begin
				report($sformatf("event kind %0d value %0d with nothing pending",
					kind, $signed(value)));
				return;
			end
			exp_ev = pending_events.pop_front();
			checked++;
			if (kind !== exp_ev.kind)
				report($sformatf("kind %0d, want %0d", kind, exp_ev.kind));
			if (value !== exp_ev.value)
				report($sformatf("value %0d, want %0d (kind %0d)", $signed(value),
					$signed(exp_ev.value), exp_ev.kind));
			if (last !== exp_ev.last)
				report($sformatf("last %0b, want %0b (kind %0d)", last, exp_ev.last,
					exp_ev.kind));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_DEADZONE;
	logic [LEVEL_W-1:0] cfg_data = '0;
	wire s_tready;
	wire m_tvalid;
	wire [VALUE_W-1:0] m_tdata;
	wire [KIND_W-1:0] m_tuser;
	wire m_tlast;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int items_sent = 0;
	int settings_used = 1;
	pointer_event_board board = new();

	always #5 clk = ~clk;

	controller_to_pointer_mapper #(.SAMPLE_BITS(SAMPLE_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// output side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_requests != hold_taken) begin
			hold_taken = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_event(m_tuser, m_tdata, m_tlast);
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// called right after a rising edge; returns in the step of the accepting edge
	task automatic send_item(logic [MODE_W-1:0] mode, logic signed [SAMPLE_W-1:0] fv,
			logic signed [SAMPLE_W-1:0] sv, logic [NUM_KEYS-1:0] buttons);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {{(DATA_W - 2 * SAMPLE_W - NUM_KEYS){1'b0}}, buttons, sv, fv};
		do @(posedge clk); while (!s_tready);
		board.note_item(mode, fv, sv, buttons);
		if (mode != MODE_UNUSED)
			items_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (board.pending_count() > 0)
			@(posedge clk);
		// items with no events may still be in the pipeline
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [LEVEL_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic program_regs(logic [LEVEL_W-1:0] dz, logic [LEVEL_W-1:0] gain,
			logic [LEVEL_W-1:0] press, logic [LEVEL_W-1:0] rel);
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_GAIN, gain);
		write_reg(REG_PRESS, press);
		write_reg(REG_RELEASE, rel);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// values clustered around a threshold, at the extremes, near zero or anywhere
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(int level);
		case ($urandom_range(5))
			0: return SAMPLE_W'(level + int'($urandom_range(4)) - 2);
			1: return SAMPLE_W'(-(level + int'($urandom_range(2))));
			2: return {1'b0, {(SAMPLE_W - 1){1'b1}}};
			3: return {1'b1, {(SAMPLE_W - 1){1'b0}}};
			4: return SAMPLE_W'(int'($urandom_range(511)) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_random();
		int pick;
		logic [MODE_W-1:0] mode;
		logic signed [SAMPLE_W-1:0] fv;
		logic signed [SAMPLE_W-1:0] sv;
		pick = $urandom_range(99);
		if (pick < 35) begin
			mode = MODE_STICK;
			fv = pick_sample(board.deadzone);
			sv = pick_sample(board.deadzone);
		end else if (pick < 65) begin
			mode = MODE_TRIGGER;
			fv = pick_sample($urandom_range(1) ? board.press_lvl : board.release_lvl);
			sv = pick_sample($urandom_range(1) ? board.press_lvl : board.release_lvl);
		end else begin
			mode = (pick < 92) ? MODE_BUTTON : MODE_UNUSED;
			fv = SAMPLE_W'($urandom);
			sv = SAMPLE_W'($urandom);
		end
		send_item(mode, fv, sv, NUM_KEYS'($urandom));
	endtask

	task automatic run_random(int count, int hold_at, int pause_at);
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_requests++;
			if (n == pause_at)
				wait_for_results();
			send_random();
		end
		wait_for_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: stick extremes and deadzone edges
		send_item(MODE_STICK, 16'sh7fff, 16'sh8000, 4'h0);
		send_item(MODE_STICK, 16'sh8000, 16'sh7fff, 4'hf);
		send_item(MODE_STICK, 16'sd6554, -16'sd6554, 4'h0);
		send_item(MODE_STICK, 16'sd6555, 16'sd0, 4'h0);
		send_item(MODE_STICK, 16'sd0, -16'sd6555, 4'h0);
		send_item(MODE_UNUSED, 16'sh7fff, 16'sh7fff, 4'hf);
		// trigger hysteresis around press and release levels
		send_item(MODE_TRIGGER, 16'sd21299, 16'sd0, 4'hf);
		send_item(MODE_TRIGGER, 16'sd14746, 16'sd21299, 4'h0);
		send_item(MODE_TRIGGER, 16'sd14745, 16'sd14746, 4'h0);
		send_item(MODE_TRIGGER, 16'sh8000, -16'sd1, 4'h0);
		send_item(MODE_TRIGGER, 16'sh7fff, 16'sh7fff, 4'h0);
		send_item(MODE_TRIGGER, 16'sh7fff, 16'sh7fff, 4'h0);
		// buttons, alone and overlapping the held triggers
		send_item(MODE_BUTTON, 16'sd0, 16'sd0, 4'b0001);
		send_item(MODE_BUTTON, 16'sh7fff, 16'sh8000, 4'b1111);
		send_item(MODE_TRIGGER, 16'sd0, 16'sd0, 4'h0);
		send_item(MODE_BUTTON, 16'sd0, 16'sd0, 4'b0000);
		send_item(MODE_BUTTON, 16'sd0, 16'sd0, 4'b0011);
		send_item(MODE_BUTTON, 16'sd0, 16'sd0, 4'b1000);
		send_item(MODE_BUTTON, 16'sd0, 16'sd0, 4'b0100);
		send_item(MODE_BUTTON, 16'sd0, 16'sd0, 4'b0000);
		wait_for_results();

		// unit gain, no deadzone: exact halves round away from zero
		program_regs(15'd0, 15'd1, PRESS_RST, RELEASE_RST);
		send_item(MODE_STICK, 16'sd16384, -16'sd16384, 4'h0);
		send_item(MODE_STICK, -16'sd16384, 16'sd16384, 4'h0);
		send_item(MODE_STICK, 16'sd16383, -16'sd16383, 4'h0);
		run_random(40, -1, -1);

		send_idle_pct = 66;
		program_regs(15'h7fff, 15'd127, 15'h7fff, 15'd0);
		run_random(45, -1, -1);

		send_idle_pct = 0;
		recv_stall_pct = 66;
		program_regs(15'd0, 15'd127, 15'd0, 15'h7fff);
		run_random(45, -1, -1);

		// long output hold-off fills the block; later the sender waits for it to drain
		send_idle_pct = 7;
		recv_stall_pct = 7;
		program_regs(15'd1000, 15'd64, 15'd20000, 15'd10000);
		run_random(50, 10, 35);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		program_regs(DEADZONE_RST, GAIN_RST, PRESS_RST, RELEASE_RST);
		run_random(50, -1, 20);

		$display("covered %0d samples over %0d register settings, with gaps, stalls and a hold-off",
			items_sent, settings_used);
		$display("%0d events checked, %0d mismatches", board.checked, board.errors);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* controller_to_pointer_mapper.f */
design/cpm_pkg.sv
design/cpm_axis_lane.sv
design/cpm_key_unit.sv
design/cpm_merge.sv
design/controller_to_pointer_mapper.sv
tb/sv/testbench.sv
